@@ sv/bbcr_pkg.sv @@
// Shared constants, frame summary type and side clamp for the blob centroid core.
package bbcr_pkg;

  localparam int MAX_SIDE   = 512;
  localparam int COL_W      = $clog2(MAX_SIDE);
  localparam int CFG_W      = 10;
  localparam logic [CFG_W-1:0] SIDE_RESET = CFG_W'(512);
  localparam int CNT_W      = 2 * COL_W + 1;
  localparam int SUM_W      = 3 * COL_W;
  localparam int DIST_W     = 2 * COL_W + 1;
  localparam int ROOT_W     = COL_W + 1;
  localparam int CX_W       = 9;
  localparam int RAD_W      = 10;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_PAD_W  = OUT_DATA_W - 2 * CX_W - RAD_W;
  localparam int Q_DEPTH    = 4;
  localparam int Q_AW       = $clog2(Q_DEPTH);
  localparam int Q_CW       = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [SUM_W-1:0] sum_x;
    logic [SUM_W-1:0] sum_y;
    logic [CNT_W-1:0] cnt;
    logic [COL_W-1:0] last_x;
    logic [COL_W-1:0] last_y;
  } bbcr_frame_t;

  function automatic logic [COL_W-1:0] side_m1(input logic [CFG_W-1:0] cfg);
    if (cfg < CFG_W'(3)) begin
      return COL_W'(2);
    end else if (int'(cfg) > MAX_SIDE) begin
      return COL_W'(MAX_SIDE - 1);
    end else begin
      return COL_W'(cfg - CFG_W'(1));
    end
  endfunction

endpackage

@@ sv/binary_blob_centroid_radius_core.sv @@
// Top level of the binary blob centroid and radius core.
//   channel   | direction | fields
//   s_axis    | in        | tdata[0] pixel_set, tuser frame_start
//   m_axis    | out       | tdata center_x, center_y, radius; tuser empty_frame
//   cfg       | in        | cfg_wdata_i side_in_use, written when cfg_we_i
// The front end takes one pixel per cycle and holds tready low only while the
// frame queue has fewer than two free slots.
// Each frame result is computed in the back end step by step:
// one division step and one root step per cycle, both units iterative.
// Reset needs no clearing pass: line store rows are always written before read.
// A stalled result holds in the output register while new pixels keep flowing as long as the frame queue has room.
module binary_blob_centroid_radius_core import bbcr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [0] pixel_set
  input  logic                  s_axis_tuser,   // [0] frame_start
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [8:0] center_x, [17:9] center_y, [27:18] radius
  output logic                  m_axis_tuser    // [0] empty_frame
);

  logic             push, pop, q_valid, q_room;
  bbcr_frame_t      push_data, q_data;
  logic [CX_W-1:0]  center_x, center_y;
  logic [RAD_W-1:0] radius;

  bbcr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .pix_valid_i   (s_axis_tvalid),
    .pix_ready_o   (s_axis_tready),
    .pix_set_i     (s_axis_tdata[0]),
    .frame_start_i (s_axis_tuser),
    .q_room_i      (q_room),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  bbcr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (q_data),
    .room_o  (q_room)
  );

  bbcr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .center_x_o  (center_x),
    .center_y_o  (center_y),
    .radius_o    (radius),
    .empty_o     (m_axis_tuser)
  );

  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, radius, center_y, center_x};

endmodule

@@ sv/bbcr_front.sv @@
// Pixel front end: position tracking, line store, 3x3 neighbor test and frame accumulation.
module bbcr_front import bbcr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  input  logic              pix_valid_i,
  output logic              pix_ready_o,
  input  logic              pix_set_i,
  input  logic              frame_start_i,
  input  logic              q_room_i,
  output logic              push_o,
  output bbcr_frame_t       push_data_o
);

  logic [CFG_W-1:0] side_cfg_q;
  logic [COL_W-1:0] col_q, row_q, side_q;
  logic             accept, first;
  logic [COL_W-1:0] cur_col, cur_row, cur_side;
  logic             col_end, row_end;

  logic [1:0]       line_mem [MAX_SIDE];
  logic [1:0]       rd_q;

  logic             s1_valid_q, s1_pix_q, s1_first_q;
  logic [COL_W-1:0] s1_x_q, s1_y_q, s1_side_q;
  logic [2:0]       w1_q, w2_q, c0, c1, c2;
  logic [3:0]       hit;

  logic             s2_valid_q, s2_first_q, s2_end_q;
  logic [COL_W-1:0] s2_x_q, s2_y_q;
  logic [3:0]       s2_hit_q;

  logic [SUM_W-1:0] sx_q, sy_q, sx_d, sy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [COL_W-1:0] lmx_q, lmy_q, lfx_q, lfy_q, lmx_d, lmy_d, lfx_d, lfy_d;
  logic             fin_any_q, fin_any_d;
  logic [COL_W-1:0] xm1, ym1;
  logic [COL_W+1:0] add_x, add_y;

  assign pix_ready_o = q_room_i;
  assign accept      = pix_valid_i & q_room_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_cfg_q <= SIDE_RESET;
    end else if (cfg_we_i) begin
      side_cfg_q <= cfg_wdata_i;
    end
  end

  assign first    = frame_start_i | ((col_q == '0) && (row_q == '0));
  assign cur_col  = frame_start_i ? '0 : col_q;
  assign cur_row  = frame_start_i ? '0 : row_q;
  assign cur_side = first ? side_m1(side_cfg_q) : side_q;
  assign col_end  = (cur_col == cur_side);
  assign row_end  = (cur_row == cur_side);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      side_q <= COL_W'(MAX_SIDE - 1);
    end else if (accept) begin
      side_q <= cur_side;
      if (col_end) begin
        col_q <= '0;
        row_q <= row_end ? '0 : cur_row + COL_W'(1);
      end else begin
        col_q <= cur_col + COL_W'(1);
        row_q <= cur_row;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q <= line_mem[cur_col];
    end
    if (s1_valid_q) begin
      line_mem[s1_x_q] <= {s1_pix_q, rd_q[1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_x_q     <= cur_col;
      s1_y_q     <= cur_row;
      s1_side_q  <= cur_side;
      s1_pix_q   <= pix_set_i;
      s1_first_q <= first;
    end
  end

  assign c0 = {s1_pix_q,
               (s1_y_q != '0) ? rd_q[1] : 1'b0,
               (s1_y_q > COL_W'(1)) ? rd_q[0] : 1'b0};
  assign c1 = (s1_x_q != '0) ? w1_q : 3'b000;
  assign c2 = (s1_x_q > COL_W'(1)) ? w2_q : 3'b000;

  always_comb begin
    hit[0] = (s1_y_q != '0) && (s1_x_q != '0) && c1[1]
             && (|{c2, c1[0], c1[2], c0});
    hit[1] = (s1_y_q != '0) && (s1_x_q == s1_side_q) && c0[1]
             && (|{c1, c0[0], c0[2]});
    hit[2] = (s1_y_q == s1_side_q) && (s1_x_q != '0) && c1[2]
             && (|{c2[2:1], c1[1], c0[2:1]});
    hit[3] = (s1_y_q == s1_side_q) && (s1_x_q == s1_side_q) && c0[2]
             && (|{c1[2:1], c0[1]});
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      w1_q <= c0;
      w2_q <= w1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_first_q <= s1_first_q;
      s2_end_q   <= (s1_x_q == s1_side_q) && (s1_y_q == s1_side_q);
      s2_x_q     <= s1_x_q;
      s2_y_q     <= s1_y_q;
      s2_hit_q   <= hit;
    end
  end

  assign xm1 = s2_x_q - COL_W'(1);
  assign ym1 = s2_y_q - COL_W'(1);

  always_comb begin
    add_x = (s2_hit_q[0] ? (COL_W+2)'(xm1) : '0)
          + (s2_hit_q[1] ? (COL_W+2)'(s2_x_q) : '0)
          + (s2_hit_q[2] ? (COL_W+2)'(xm1) : '0)
          + (s2_hit_q[3] ? (COL_W+2)'(s2_x_q) : '0);
    add_y = (s2_hit_q[0] ? (COL_W+2)'(ym1) : '0)
          + (s2_hit_q[1] ? (COL_W+2)'(ym1) : '0)
          + (s2_hit_q[2] ? (COL_W+2)'(s2_y_q) : '0)
          + (s2_hit_q[3] ? (COL_W+2)'(s2_y_q) : '0);
    sx_d  = (s2_first_q ? '0 : sx_q) + SUM_W'(add_x);
    sy_d  = (s2_first_q ? '0 : sy_q) + SUM_W'(add_y);
    cnt_d = (s2_first_q ? '0 : cnt_q) + CNT_W'(s2_hit_q[0]) + CNT_W'(s2_hit_q[1])
          + CNT_W'(s2_hit_q[2]) + CNT_W'(s2_hit_q[3]);
    lmx_d = s2_first_q ? '0 : lmx_q;
    lmy_d = s2_first_q ? '0 : lmy_q;
    if (s2_hit_q[1]) begin
      lmx_d = s2_x_q;
      lmy_d = ym1;
    end else if (s2_hit_q[0]) begin
      lmx_d = xm1;
      lmy_d = ym1;
    end
    lfx_d = s2_first_q ? '0 : lfx_q;
    lfy_d = s2_first_q ? '0 : lfy_q;
    if (s2_hit_q[3]) begin
      lfx_d = s2_x_q;
      lfy_d = s2_y_q;
    end else if (s2_hit_q[2]) begin
      lfx_d = xm1;
      lfy_d = s2_y_q;
    end
    fin_any_d = (s2_first_q ? 1'b0 : fin_any_q) | s2_hit_q[2] | s2_hit_q[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q      <= '0;
      sy_q      <= '0;
      cnt_q     <= '0;
      lmx_q     <= '0;
      lmy_q     <= '0;
      lfx_q     <= '0;
      lfy_q     <= '0;
      fin_any_q <= 1'b0;
    end else if (s2_valid_q) begin
      sx_q      <= sx_d;
      sy_q      <= sy_d;
      cnt_q     <= cnt_d;
      lmx_q     <= lmx_d;
      lmy_q     <= lmy_d;
      lfx_q     <= lfx_d;
      lfy_q     <= lfy_d;
      fin_any_q <= fin_any_d;
    end
  end

  assign push_o             = s2_valid_q & s2_end_q;
  assign push_data_o.sum_x  = sx_d;
  assign push_data_o.sum_y  = sy_d;
  assign push_data_o.cnt    = cnt_d;
  assign push_data_o.last_x = fin_any_d ? lfx_d : lmx_d;
  assign push_data_o.last_y = fin_any_d ? lfy_d : lmy_d;

endmodule

@@ sv/bbcr_queue.sv @@
// Short queue of finished frame summaries between front end and back end.
module bbcr_queue import bbcr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  bbcr_frame_t data_i,
  input  logic        pop_i,
  output logic        valid_o,
  output bbcr_frame_t data_o,
  output logic        room_o
);

  bbcr_frame_t     entry_q [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_CW-1:0] count_q;
  logic            do_pop;

  assign do_pop  = pop_i & (count_q != '0);
  assign valid_o = (count_q != '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign room_o  = (count_q < Q_CW'(Q_DEPTH - 1));

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + Q_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + Q_AW'(1);
      end
      count_q <= count_q + Q_CW'(push_i) - Q_CW'(do_pop);
    end
  end

endmodule

@@ sv/bbcr_back.sv @@
// Back end: ceiling divisions, squared distance, ceiling square root and result register.
module bbcr_back import bbcr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  bbcr_frame_t      q_data_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [CX_W-1:0]  center_x_o,
  output logic [CX_W-1:0]  center_y_o,
  output logic [RAD_W-1:0] radius_o,
  output logic             empty_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_SQR  = 3'd2;
  localparam logic [2:0] ST_SUM  = 3'd3;
  localparam logic [2:0] ST_ROOT = 3'd4;
  localparam logic [2:0] ST_FIX  = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;
  localparam int REM_W  = SUM_W + 1;
  localparam int STEP_W = $clog2(COL_W);
  localparam int SQ_W   = 2 * ROOT_W;

  logic [2:0]        state_q;
  logic [REM_W-1:0]  remx_q, remy_q, dsh_q;
  logic [COL_W-1:0]  qx_q, qy_q, lx_q, ly_q, ax, ay;
  logic [STEP_W-1:0] step_q;
  logic [2*COL_W-1:0] sqx_q, sqy_q;
  logic [DIST_W-1:0] d_q;
  logic [ROOT_W-1:0] root_q, rbit_q, trial;
  logic [SQ_W-1:0]   tsq, rsq;
  logic              ge_x, ge_y;
  logic [CX_W-1:0]   cx_q, cy_q;
  logic [RAD_W-1:0]  rad_q;
  logic              empty_q;

  assign pop_o       = (state_q == ST_IDLE) & q_valid_i;
  assign out_valid_o = (state_q == ST_OUT);
  assign center_x_o  = cx_q;
  assign center_y_o  = cy_q;
  assign radius_o    = rad_q;
  assign empty_o     = empty_q;

  assign ge_x  = (remx_q >= dsh_q);
  assign ge_y  = (remy_q >= dsh_q);
  assign ax    = (lx_q >= qx_q) ? lx_q - qx_q : qx_q - lx_q;
  assign ay    = (ly_q >= qy_q) ? ly_q - qy_q : qy_q - ly_q;
  assign trial = root_q | rbit_q;
  assign tsq   = SQ_W'(trial) * SQ_W'(trial);
  assign rsq   = SQ_W'(root_q) * SQ_W'(root_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            state_q <= (q_data_i.cnt == '0) ? ST_OUT : ST_DIV;
          end
        end
        ST_DIV: begin
          if (step_q == '0) begin
            state_q <= ST_SQR;
          end
        end
        ST_SQR:  state_q <= ST_SUM;
        ST_SUM:  state_q <= ST_ROOT;
        ST_ROOT: begin
          if (rbit_q[0]) begin
            state_q <= ST_FIX;
          end
        end
        ST_FIX:  state_q <= ST_OUT;
        ST_OUT: begin
          if (out_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          remx_q  <= REM_W'(q_data_i.sum_x) + REM_W'(q_data_i.cnt) - REM_W'(1);
          remy_q  <= REM_W'(q_data_i.sum_y) + REM_W'(q_data_i.cnt) - REM_W'(1);
          dsh_q   <= REM_W'(q_data_i.cnt) << (COL_W - 1);
          step_q  <= STEP_W'(COL_W - 1);
          qx_q    <= '0;
          qy_q    <= '0;
          lx_q    <= q_data_i.last_x;
          ly_q    <= q_data_i.last_y;
          cx_q    <= '0;
          cy_q    <= '0;
          rad_q   <= '0;
          empty_q <= (q_data_i.cnt == '0);
        end
      end
      ST_DIV: begin
        if (ge_x) begin
          remx_q <= remx_q - dsh_q;
        end
        if (ge_y) begin
          remy_q <= remy_q - dsh_q;
        end
        qx_q   <= {qx_q[COL_W-2:0], ge_x};
        qy_q   <= {qy_q[COL_W-2:0], ge_y};
        dsh_q  <= dsh_q >> 1;
        step_q <= step_q - STEP_W'(1);
      end
      ST_SQR: begin
        sqx_q <= (2*COL_W)'(ax) * (2*COL_W)'(ax);
        sqy_q <= (2*COL_W)'(ay) * (2*COL_W)'(ay);
      end
      ST_SUM: begin
        d_q    <= DIST_W'(sqx_q) + DIST_W'(sqy_q);
        root_q <= '0;
        rbit_q <= {1'b1, {(ROOT_W-1){1'b0}}};
      end
      ST_ROOT: begin
        if (tsq <= SQ_W'(d_q)) begin
          root_q <= trial;
        end
        rbit_q <= rbit_q >> 1;
      end
      ST_FIX: begin
        cx_q  <= CX_W'(qx_q);
        cy_q  <= CX_W'(qy_q);
        rad_q <= (rsq < SQ_W'(d_q)) ? RAD_W'(root_q + ROOT_W'(1)) : RAD_W'(root_q);
      end
      default: begin
      end
    endcase
  end

endmodule

@@ sv/bbcr_checker.sv @@
// Port-level checker for the blob centroid core and its bind.
module bbcr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  hold_stalled_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  empty_has_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 32'd0)
    else $error("empty frame with nonzero fields");

  radius_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[27:18] <= 10'd723 && m_axis_tdata[31:28] == 4'd0)
    else $error("radius beyond largest distance in image");

  no_result_in_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

endmodule

bind binary_blob_centroid_radius_core bbcr_checker u_bbcr_checker (.*);

@@ sim/testbench.sv @@
// Self-checking testbench for the binary blob centroid and radius core.
module testbench;
  import bbcr_pkg::*;

  localparam int DRAIN_CYCLES = 64;
  localparam int LONG_HOLD    = 3000;
  localparam int RANDOM_ITEMS = 400;
  localparam int RANDOM_BLOBS = 5;

  typedef struct packed {
    logic             empty;
    logic [RAD_W-1:0] radius;
    logic [CX_W-1:0]  cy;
    logic [CX_W-1:0]  cx;
  } blob_result_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b1;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_W-1:0]      cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // [0] pixel_set
  logic                  s_axis_tuser  = 1'b0; // [0] frame_start
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;         // [8:0] center_x, [17:9] center_y, [27:18] radius
  logic                  m_axis_tuser;         // [0] empty_frame

  binary_blob_centroid_radius_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Blob predictor state.
  bit              line_bits [3][MAX_SIDE];
  int              col_pos;
  int              row_pos;
  int              side_cfg;
  int              side_now;
  longint unsigned sum_cols;
  longint unsigned sum_rows;
  longint unsigned hit_total;
  int              last_col;
  int              last_row;
  int              blobs_predicted;

  blob_result_t    expected_blobs [$];
  int              error_count;
  bit              tx_idle_on;
  bit              rx_idle_on;
  int              stall_requests;
  int              stall_seen;
  int              rx_hold_left;
  int              rx_gap_left;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int clamp_side(input int s);
    if (s < 3) return 3;
    if (s > MAX_SIDE) return MAX_SIDE;
    return s;
  endfunction

  function automatic bit pixel_at(input int px, input int py);
    if (px < 0 || py < 0 || px >= side_now || py >= side_now) return 1'b0;
    return line_bits[py % 3][px];
  endfunction

  function automatic void judge_pixel(input int px, input int py);
    bit any_set;
    any_set = 1'b0;
    if (!pixel_at(px, py)) return;
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        if ((dx != 0 || dy != 0) && pixel_at(px + dx, py + dy)) any_set = 1'b1;
      end
    end
    if (!any_set) return;
    sum_cols  += longint'(px);
    sum_rows  += longint'(py);
    hit_total += 1;
    last_col   = px;
    last_row   = py;
  endfunction

  function automatic longint unsigned ceil_root(input longint unsigned d);
    longint unsigned r;
    r = 0;
    while ((r + 1) * (r + 1) <= d) r++;
    if (r * r < d) r++;
    return r;
  endfunction

  function automatic void clear_blob();
    col_pos   = 0;
    row_pos   = 0;
    sum_cols  = 0;
    sum_rows  = 0;
    hit_total = 0;
    last_col  = 0;
    last_row  = 0;
  endfunction

  function automatic void reset_predictor();
    foreach (line_bits[i, j]) line_bits[i][j] = 1'b0;
    clear_blob();
    side_cfg = int'(SIDE_RESET);
    side_now = clamp_side(side_cfg);
  endfunction

  function automatic void predict_pixel(input bit pix, input bit fs);
    blob_result_t    res;
    longint unsigned cx;
    longint unsigned cy;
    longint unsigned d;
    longint          ex;
    longint          ey;
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos == 0 && row_pos == 0) begin
      clear_blob();
      side_now = clamp_side(side_cfg);
    end
    line_bits[row_pos % 3][col_pos] = pix;
    if (row_pos > 0) begin
      if (col_pos > 0) judge_pixel(col_pos - 1, row_pos - 1);
      if (col_pos == side_now - 1) judge_pixel(col_pos, row_pos - 1);
    end
    col_pos++;
    if (col_pos >= side_now) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos < side_now) return;
    for (int px = 0; px < side_now; px++) judge_pixel(px, side_now - 1);
    col_pos = 0;
    row_pos = 0;
    res = '0;
    if (hit_total == 0) begin
      res.empty = 1'b1;
    end else begin
      cx = (sum_cols + hit_total - 1) / hit_total;
      cy = (sum_rows + hit_total - 1) / hit_total;
      ex = longint'(last_col) - longint'(cx);
      ey = longint'(last_row) - longint'(cy);
      d  = longint'(ex * ex) + longint'(ey * ey);
      res.cx     = cx[CX_W-1:0];
      res.cy     = cy[CX_W-1:0];
      res.radius = RAD_W'(ceil_root(d));
    end
    expected_blobs.push_back(res);
    blobs_predicted++;
  endfunction

  task automatic note_error(input string what, input blob_result_t want,
                            input blob_result_t got);
    error_count++;
    if (error_count <= 10) begin
      $display("%s: expected cx=%0d cy=%0d radius=%0d empty=%0b, got cx=%0d cy=%0d radius=%0d empty=%0b",
               what, want.cx, want.cy, want.radius, want.empty,
               got.cx, got.cy, got.radius, got.empty);
    end
  endtask

  always @(posedge clk_i) begin
    blob_result_t got;
    blob_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.cx     = m_axis_tdata[CX_W-1:0];
      got.cy     = m_axis_tdata[2*CX_W-1:CX_W];
      got.radius = m_axis_tdata[2*CX_W+RAD_W-1:2*CX_W];
      got.empty  = m_axis_tuser;
      if (expected_blobs.size() == 0) begin
        note_error("result with nothing pending", '0, got);
      end else begin
        want = expected_blobs.pop_front();
        if (got.cx !== want.cx || got.cy !== want.cy || got.radius !== want.radius ||
            got.empty !== want.empty) begin
          note_error("result mismatch", want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_gap_left   <= 0;
      rx_hold_left  <= 0;
      stall_seen    <= 0;
    end else if (stall_seen != stall_requests) begin
      stall_seen    <= stall_requests;
      rx_hold_left  <= LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left  <= rx_hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!rx_idle_on) begin
      m_axis_tready <= 1'b1;
    end else if (rx_gap_left != 0) begin
      rx_gap_left   <= rx_gap_left - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      rx_gap_left   <= pick_gap();
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_pixel(input bit pix, input bit fs);
    int gap;
    gap = tx_idle_on ? pick_gap() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'(pix);
    s_axis_tuser  <= fs;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_pixel(pix, fs);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_blobs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_side(input int value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= CFG_W'(value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    side_cfg     = value & ((1 << CFG_W) - 1);
  endtask

  // Send one frame at the current side; stop early at cut_at when it is not negative.
  task automatic send_frame(input int density, input int cut_at, output int sent);
    int n;
    bit start_bit;
    bit fs;
    n         = clamp_side(side_cfg) * clamp_side(side_cfg);
    start_bit = (col_pos != 0 || row_pos != 0) ? 1'b1 : 1'($urandom_range(0, 1));
    sent      = 0;
    for (int i = 0; i < n; i++) begin
      if (cut_at >= 0 && i == cut_at) break;
      fs = (i == 0) ? start_bit : ($urandom_range(0, 299) == 0);
      send_pixel($urandom_range(0, 99) < density, fs);
      sent++;
    end
  endtask

  task automatic test_reset_side();
    for (int i = 0; i < 12; i++) send_pixel(1'b1, i == 0);
  endtask

  task automatic test_restart_mid_frame();
    int sent;
    write_side(0);
    send_pixel(1'b1, 1'b1);
    send_frame(100, 8, sent);
  endtask

  task automatic test_isolated_auto_start();
    while (col_pos != 0 || row_pos != 0) send_pixel(1'b0, 1'b0);
    for (int i = 0; i < 9; i++) send_pixel(i == 4, 1'b0);
  endtask

  task automatic test_side_change_mid_frame();
    logic [15:0] mask;
    mask = 16'b1000_0100_0000_0011;
    write_side(4);
    for (int i = 0; i < 5; i++) send_pixel(mask[i], i == 0);
    write_side(2);
    for (int i = 5; i < 16; i++) send_pixel(mask[i], 1'b0);
  endtask

  task automatic test_largest_side();
    bit pix;
    write_side(1023);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    for (int i = 0; i < MAX_SIDE + 8; i++) begin
      pix = (i < 2) || (i == MAX_SIDE) || ($urandom_range(0, 99) < 6);
      send_pixel(pix, i == 0);
    end
  endtask

  task automatic test_backpressure();
    int sent;
    write_side(3);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b1;
    stall_requests++;
    repeat (15) send_frame($urandom_range(30, 90), -1, sent);
  endtask

  task automatic test_random_frames();
    int items;
    int base;
    int r;
    int density;
    int n;
    int cut;
    int sent;
    items = 0;
    base  = blobs_predicted;
    while (items < RANDOM_ITEMS || blobs_predicted - base < RANDOM_BLOBS) begin
      r = $urandom_range(0, 99);
      if (r < 70)      write_side($urandom_range(3, 8));
      else if (r < 90) write_side($urandom_range(9, 16));
      else if (r < 96) write_side($urandom_range(17, 24));
      else             write_side($urandom_range(0, 2));
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 5))
          0: density = 0;
          1: density = 5;
          2: density = 20;
          3: density = 40;
          4: density = 70;
          default: density = 100;
        endcase
        n   = clamp_side(side_cfg) * clamp_side(side_cfg);
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, n - 1) : -1;
        send_frame(density, cut, sent);
        items += sent;
      end
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    reset_predictor();
    error_count     = 0;
    blobs_predicted = 0;
    stall_requests  = 0;
    tx_idle_on      = 1'b1;
    rx_idle_on      = 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_side();
    test_restart_mid_frame();
    test_isolated_auto_start();
    test_side_change_mid_frame();
    test_largest_side();
    test_backpressure();
    test_random_frames();
    wait_idle();
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
